// ===== rtl/ptas_pkg.sv =====
// Shared types, codes and helpers for the peer table aging selector.
`timescale 1ns / 1ps
`default_nettype none
package ptas_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int KEY_BYTES   = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] OP_OBSERVE = 3'd0;
  localparam logic [2:0] OP_APPLY   = 3'd1;
  localparam logic [2:0] OP_SEL_SHR = 3'd2;
  localparam logic [2:0] OP_SEL_EP  = 3'd3;
  localparam logic [2:0] OP_EXPIRE  = 3'd4;
  localparam logic [2:0] OP_FIND    = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_AMBIGUOUS = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [7:0] NEW_RSSI = 8'h81;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SCAN2,
    S_COMPACT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [2:0]  sig;
    logic [47:0] t_first;
    logic [47:0] t_last;
    logic [47:0] t_ble;
    logic [47:0] t_awdl;
    logic [47:0] t_share;
    logic [7:0]  rssi_ble;
    logic [7:0]  rssi_awdl;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [47:0] mac;
    logic [15:0] port;
    logic        complete;
    logic        dead;
  } entry_t;

  typedef struct packed {
    logic rotate;
    logic compact;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic cand;
    logic append;
    logic dead;
  } step_flags_t;

  function automatic logic [63:0] key_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (len > 4'(b)) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ptas_cell.sv =====
// One table cell: holds one entry and takes its upper neighbor's entry on rotate, or on compact when chained.
`timescale 1ns / 1ps
`default_nettype none
module ptas_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ptas_pkg::cell_ctl_t ctl,
  input  wire ptas_pkg::entry_t    up,
  input  wire logic               chain_in,
  output      ptas_pkg::entry_t    q,
  output      logic               chain_out
);

  // During compaction every cell at or above the lowest dead entry moves down one place.
  assign chain_out = ctl.compact & (chain_in | q.dead);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctl.rotate || chain_out) begin
      q <= up;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ptas_step.sv =====
// Head-of-ring step logic: examines and updates the entry leaving cell zero.
`timescale 1ns / 1ps
`default_nettype none
module ptas_step (
  input  wire ptas_pkg::entry_t        e,
  input  wire logic [2:0]              op,
  input  wire logic [63:0]             key,
  input  wire logic [3:0]              key_len,
  input  wire logic [2:0]              sig,
  input  wire logic [47:0]             t,
  input  wire logic [7:0]              rssi,
  input  wire logic [63:0]             addr_hi,
  input  wire logic [63:0]             addr_lo,
  input  wire logic                    addr_ok,
  input  wire logic [47:0]             mac,
  input  wire logic                    mac_ok,
  input  wire logic [15:0]             port,
  input  wire logic [47:0]             sel_max,
  input  wire logic [47:0]             exp_max,
  input  wire logic [ptas_pkg::IDX_W-1:0] idx,
  input  wire logic [ptas_pkg::CNT_W-1:0] count,
  input  wire logic                    hit,
  input  wire logic                    pass2,
  input  wire logic [ptas_pkg::IDX_W-1:0] slot,
  output      ptas_pkg::entry_t        e_next,
  output      ptas_pkg::step_flags_t   flags
);

  localparam int CW = ptas_pkg::CNT_W;

  logic        in_range;
  logic        key_match;
  logic [47:0] age_ref;
  logic [47:0] age_max;
  logic [47:0] diff;
  logic        not_after;
  logic        in_window;
  logic        sel_ok;
  ptas_pkg::entry_t base;

  always_comb begin
    in_range  = CW'(idx) < count;
    key_match = in_range && (e.key_len == key_len) && (e.key == key);

    // One age unit serves both the expire test and the freshness test.
    age_ref   = (op == ptas_pkg::OP_EXPIRE) ? e.t_last : e.t_share;
    age_max   = (op == ptas_pkg::OP_EXPIRE) ? exp_max : sel_max;
    diff      = t - age_ref;
    not_after = age_ref <= t;
    in_window = not_after && (diff <= age_max);

    sel_ok = (op == ptas_pkg::OP_SEL_EP) ? e.complete : e.sig[2];

    flags.match  = key_match;
    flags.append = (op == ptas_pkg::OP_OBSERVE) && !hit && (CW'(idx) == count);
    flags.dead   = (op == ptas_pkg::OP_EXPIRE) && in_range && !(!not_after || in_window);
    case (op) inside
      ptas_pkg::OP_APPLY:
        flags.cand = in_range && e.sig[1] && (e.addr_hi == addr_hi) && (e.addr_lo == addr_lo);
      ptas_pkg::OP_SEL_SHR, ptas_pkg::OP_SEL_EP:
        flags.cand = in_range && sel_ok && in_window;
      default:
        flags.cand = 1'b0;
    endcase

    base = e;
    if (flags.append) begin
      base           = '0;
      base.key       = key;
      base.key_len   = key_len;
      base.t_first   = t;
      base.rssi_ble  = ptas_pkg::NEW_RSSI;
      base.rssi_awdl = ptas_pkg::NEW_RSSI;
    end

    e_next = base;
    if ((op == ptas_pkg::OP_OBSERVE) && (key_match || flags.append)) begin
      e_next.sig = base.sig | sig;
      if (t > base.t_last) e_next.t_last = t;
      if (sig[0]) begin
        e_next.t_ble    = t;
        e_next.rssi_ble = rssi;
      end
      if (sig[1]) begin
        e_next.t_awdl    = t;
        e_next.rssi_awdl = rssi;
        if (mac_ok) e_next.mac = mac;
        if (addr_ok) begin
          e_next.addr_hi = addr_hi;
          e_next.addr_lo = addr_lo;
        end
      end
      if (sig[2]) e_next.t_share = t;
    end
    if ((op == ptas_pkg::OP_APPLY) && pass2 && (idx == slot)) begin
      e_next.sig[2]   = 1'b1;
      e_next.t_share  = t;
      if (t > e.t_last) e_next.t_last = t;
      e_next.port     = port;
      e_next.complete = 1'b1;
    end
    if (flags.dead) e_next.dead = 1'b1;
  end

endmodule
`default_nettype wire

// ===== rtl/peer_table_aging_selector_unit.sv =====
// Peer table top level: ring of entry cells, head step logic and operation sequencer.
// Observe, find and selects make one rotating pass over the 32-cell ring, one entry a cycle; apply
// endpoint adds a second rotating pass and expire a compacting pass; an invalid word makes no pass.
// One word is in work at a time: a new word is taken only once the last one is done, later while
// a finished result waits in the output register.
// Synchronous reset clears the table, the entry count and both age registers.
`timescale 1ns / 1ps
`default_nettype none
module peer_table_aging_selector_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output      logic               item_stall,
  input  wire logic [2:0]         operation,
  input  wire logic [63:0]        peer_key,
  input  wire logic [3:0]         key_length,
  input  wire logic [2:0]         signal_bits,
  input  wire logic [47:0]        time_ms,
  input  wire logic signed [7:0]  rssi,
  input  wire logic [63:0]        address_high,
  input  wire logic [63:0]        address_low,
  input  wire logic               address_present,
  input  wire logic [47:0]        hw_mac,
  input  wire logic               mac_present,
  input  wire logic [15:0]        service_port,
  output      logic               result_valid,
  input  wire logic               result_stall,
  output      logic [2:0]         status,
  output      logic [4:0]         slot_index,
  output      logic [5:0]         removed_count,
  output      logic [2:0]         entry_signals,
  output      logic [15:0]        entry_port,
  output      logic [63:0]        entry_address_high,
  output      logic [63:0]        entry_address_low,
  output      logic [47:0]        entry_last_seen,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [47:0]        cfg_data
);

  localparam int IW = ptas_pkg::IDX_W;
  localparam int CW = ptas_pkg::CNT_W;

  ptas_pkg::state_t state, state_next;

  logic [47:0]   sel_max;
  logic [47:0]   exp_max;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;

  logic [2:0]  op;
  logic [63:0] key;
  logic [3:0]  key_len;
  logic [2:0]  sig;
  logic [47:0] t;
  logic [7:0]  rssi_r;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic        addr_ok;
  logic [47:0] mac;
  logic        mac_ok;
  logic [15:0] port;

  logic          hit;
  logic          amb;
  logic          appended;
  logic [IW-1:0] slot;
  logic [CW-1:0] removed;
  logic [2:0]    res_status;
  logic [2:0]    res_status_next;
  ptas_pkg::entry_t cap;

  ptas_pkg::entry_t      cell_q [ptas_pkg::TABLE_DEPTH];
  logic                  chain  [ptas_pkg::TABLE_DEPTH];
  ptas_pkg::entry_t      e_next;
  ptas_pkg::entry_t      top_in;
  ptas_pkg::step_flags_t flags;
  ptas_pkg::cell_ctl_t   ctl;

  logic accept;
  logic last_step;
  logic key_ok;
  logic bad_item;
  logic report;
  logic capture;

  assign item_stall = (state != ptas_pkg::S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign last_step  = (idx == IW'(ptas_pkg::TABLE_DEPTH - 1));
  assign key_ok     = (key_length != 4'd0) && (key_length <= 4'(ptas_pkg::KEY_BYTES));

  always_comb begin
    case (operation) inside
      ptas_pkg::OP_OBSERVE: bad_item = !key_ok || (signal_bits == 3'd0);
      ptas_pkg::OP_APPLY:   bad_item = (service_port == 16'd0);
      ptas_pkg::OP_SEL_SHR, ptas_pkg::OP_SEL_EP, ptas_pkg::OP_EXPIRE: bad_item = 1'b0;
      ptas_pkg::OP_FIND:    bad_item = !key_ok;
      default:              bad_item = 1'b1;
    endcase
  end

  ptas_step u_step (
    .e       (cell_q[0]),
    .op      (op),
    .key     (key),
    .key_len (key_len),
    .sig     (sig),
    .t       (t),
    .rssi    (rssi_r),
    .addr_hi (addr_hi),
    .addr_lo (addr_lo),
    .addr_ok (addr_ok),
    .mac     (mac),
    .mac_ok  (mac_ok),
    .port    (port),
    .sel_max (sel_max),
    .exp_max (exp_max),
    .idx     (idx),
    .count   (count),
    .hit     (hit),
    .pass2   (state == ptas_pkg::S_SCAN2),
    .slot    (slot),
    .e_next  (e_next),
    .flags   (flags)
  );

  assign ctl.rotate  = (state == ptas_pkg::S_SCAN) || (state == ptas_pkg::S_SCAN2);
  assign ctl.compact = (state == ptas_pkg::S_COMPACT);
  assign top_in      = ctl.compact ? '0 : e_next;

  for (genvar k = 0; k < ptas_pkg::TABLE_DEPTH; k++) begin : g_cell
    ptas_pkg::entry_t up_k;
    logic             chain_in_k;
    if (k == ptas_pkg::TABLE_DEPTH - 1) begin : g_top
      assign up_k = top_in;
    end else begin : g_mid
      assign up_k = cell_q[k+1];
    end
    if (k == 0) begin : g_first
      assign chain_in_k = 1'b0;
    end else begin : g_rest
      assign chain_in_k = chain[k-1];
    end
    ptas_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .up        (up_k),
      .chain_in  (chain_in_k),
      .q         (cell_q[k]),
      .chain_out (chain[k])
    );
  end

  // Which head event records the reported entry in the current pass.
  always_comb begin
    capture = 1'b0;
    if (state == ptas_pkg::S_SCAN) begin
      case (op) inside
        ptas_pkg::OP_OBSERVE: capture = (flags.match || flags.append) && !hit;
        ptas_pkg::OP_FIND:    capture = flags.match && !hit;
        ptas_pkg::OP_SEL_SHR, ptas_pkg::OP_SEL_EP: capture = flags.cand && !hit;
        default:              capture = 1'b0;
      endcase
    end else if (state == ptas_pkg::S_SCAN2) begin
      capture = (idx == slot);
    end
  end

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    unique case (state) inside
      ptas_pkg::S_IDLE: begin
        if (accept) begin
          if (bad_item) begin
            state_next      = ptas_pkg::S_FINISH;
            res_status_next = ptas_pkg::ST_INVALID;
          end else begin
            state_next = ptas_pkg::S_SCAN;
          end
        end
      end
      ptas_pkg::S_SCAN: begin
        if (last_step) state_next = ptas_pkg::S_DECIDE;
      end
      ptas_pkg::S_DECIDE: begin
        state_next = ptas_pkg::S_FINISH;
        case (op)
          ptas_pkg::OP_OBSERVE: res_status_next = hit ? ptas_pkg::ST_OK : ptas_pkg::ST_FULL;
          ptas_pkg::OP_APPLY: begin
            if (amb) begin
              res_status_next = ptas_pkg::ST_AMBIGUOUS;
            end else if (!hit) begin
              res_status_next = ptas_pkg::ST_NOT_FOUND;
            end else begin
              res_status_next = ptas_pkg::ST_OK;
              state_next      = ptas_pkg::S_SCAN2;
            end
          end
          ptas_pkg::OP_EXPIRE: begin
            res_status_next = ptas_pkg::ST_OK;
            state_next      = ptas_pkg::S_COMPACT;
          end
          default: begin
            res_status_next = amb ? ptas_pkg::ST_AMBIGUOUS :
                              (hit ? ptas_pkg::ST_OK : ptas_pkg::ST_NOT_FOUND);
          end
        endcase
      end
      ptas_pkg::S_SCAN2, ptas_pkg::S_COMPACT: begin
        if (last_step) state_next = ptas_pkg::S_FINISH;
      end
      ptas_pkg::S_FINISH: begin
        if (!result_valid || !result_stall) state_next = ptas_pkg::S_IDLE;
      end
      default: state_next = ptas_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptas_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_max <= '0;
      exp_max <= '0;
    end else if (cfg_write) begin
      if (cfg_index) exp_max <= cfg_data;
      else           sel_max <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      hit        <= 1'b0;
      amb        <= 1'b0;
      appended   <= 1'b0;
      removed    <= '0;
      res_status <= ptas_pkg::ST_OK;
    end else begin
      res_status <= res_status_next;
      if (accept) begin
        idx      <= '0;
        hit      <= 1'b0;
        amb      <= 1'b0;
        appended <= 1'b0;
        removed  <= '0;
      end
      if ((state == ptas_pkg::S_SCAN) || (state == ptas_pkg::S_SCAN2) ||
          (state == ptas_pkg::S_COMPACT)) begin
        idx <= idx + IW'(1);
      end
      if (state == ptas_pkg::S_DECIDE) begin
        idx <= '0;
        if (op == ptas_pkg::OP_OBSERVE && appended) count <= count + CW'(1);
        if (op == ptas_pkg::OP_EXPIRE) count <= count - removed;
      end
      if (state == ptas_pkg::S_SCAN) begin
        if (capture || flags.cand) hit <= 1'b1;
        if (flags.cand && hit) amb <= 1'b1;
        if (capture) appended <= flags.append;
        if (flags.dead) removed <= removed + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= operation;
      key     <= peer_key & ptas_pkg::key_mask(key_length);
      key_len <= key_length;
      sig     <= signal_bits;
      t       <= time_ms;
      rssi_r  <= $unsigned(rssi);
      addr_hi <= address_high;
      addr_lo <= address_low;
      addr_ok <= address_present;
      mac     <= hw_mac;
      mac_ok  <= mac_present;
      port    <= service_port;
      slot    <= '0;
      cap     <= '0;
    end else begin
      if (capture) cap <= e_next;
      if ((state == ptas_pkg::S_SCAN) && (capture || (flags.cand && !hit))) slot <= idx;
    end
  end

  // An entry is reported only on success of an operation that names one.
  assign report = (res_status == ptas_pkg::ST_OK) && (op != ptas_pkg::OP_EXPIRE);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ptas_pkg::S_FINISH && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ptas_pkg::S_FINISH && (!result_valid || !result_stall)) begin
      status             <= res_status;
      slot_index         <= report ? 5'(slot) : 5'd0;
      removed_count      <= 6'(removed);
      entry_signals      <= report ? cap.sig : 3'd0;
      entry_port         <= report ? cap.port : 16'd0;
      entry_address_high <= report ? cap.addr_hi : 64'd0;
      entry_address_low  <= report ? cap.addr_lo : 64'd0;
      entry_last_seen    <= report ? cap.t_last : 48'd0;
    end
  end

endmodule
`default_nettype wire
